/* hdl/sllm_pkg.sv */
// Package for the static linked list manager: command codes, sequencer states,
// stream field widths and parameter defaults. No dependencies.
package sllm_pkg;

  localparam int NODES_DEFAULT      = 64;
  localparam int DATA_WIDTH_DEFAULT = 32;

  localparam int CMD_W     = 3;
  localparam int VALUE_W   = 32;
  localparam int POS_W     = 6;
  localparam int IN_DATA_W = 32;
  localparam int IN_USER_W = 8;
  localparam int OUT_DATA_W = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT  = 3'd0,
    CMD_FIND    = 3'd1,
    CMD_DELETE  = 3'd2,
    CMD_REVERSE = 3'd3,
    CMD_CLEAR   = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_STEP   = 3'b010,
    ST_RESULT = 3'b100
  } state_t;

endpackage

/* hdl/sllm_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sllm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/static_linked_list_manager.sv */
// Static linked list manager: list and free chain held in two RAMs, walked by
// a one-node-per-cycle sequencer. Depends on sllm_pkg and sllm_ram.
//
// Usage:
//   Commands arrive on the s_ stream (s_tuser = command, s_tdata = value), one
//   result leaves on the m_ stream per command. Commands are taken one at a
//   time: s_tready is high only while the sequencer is idle.
//   Clear and unused codes go straight to the result; insert takes the free
//   head without a walk; delete and reverse walk the whole list, and find
//   walks it until the first match. A walk visits at most NODES list nodes.
//   Each visited node costs one read of the link and value RAMs; that read
//   loop sets the rate.
//   Heads of the list and the free chain live in registers; entries 0 and 1
//   of the RAMs are unused.
//   Reset empties the list and sets a fill mark so that every node not yet
//   handed out reads as the next free one. No clearing pass runs: s_tready
//   rises in the first cycle after reset. Clear does the same.
//   When the receiver stalls, the finished result holds in the output
//   register; one more command may be taken and run, and it waits until the
//   output register frees up.
module static_linked_list_manager #(
  parameter int NODES      = sllm_pkg::NODES_DEFAULT,
  parameter int DATA_WIDTH = sllm_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [sllm_pkg::IN_DATA_W-1:0]  s_tdata,   // [31:0] value
  input  logic [sllm_pkg::IN_USER_W-1:0]  s_tuser,   // [2:0] cmd, [7:3] zero
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [sllm_pkg::OUT_DATA_W-1:0] m_tdata    // [5:0] position, [6] found,
                                                     // [7] status, [8] empty_res,
                                                     // [9] full_res, [15:10] zero
);

  import sllm_pkg::*;

  localparam int IDX_W = $clog2(NODES);
  localparam int CNT_W = IDX_W + 1;
  localparam logic [CNT_W-1:0] NODES_C    = CNT_W'(NODES);
  localparam logic [IDX_W-1:0] FIRST_NODE = IDX_W'(2);
  localparam logic [IDX_W-1:0] LAST_NODE  = IDX_W'(NODES - 1);

  state_t                state, state_next;
  cmd_t                  cmd_q, cmd_next;
  logic [DATA_WIDTH-1:0] val_q, val_next;
  logic [IDX_W-1:0]      cur, cur_next;
  logic [IDX_W-1:0]      prev, prev_next;
  logic [CNT_W-1:0]      steps, steps_next;
  logic                  dirty, dirty_next;
  logic [IDX_W-1:0]      head, head_next;
  logic [IDX_W-1:0]      free_head, free_head_next;
  logic [CNT_W-1:0]      hwm, hwm_next;
  logic [IDX_W-1:0]      res_pos, res_pos_next;
  logic                  res_found, res_found_next;
  logic                  res_status, res_status_next;
  logic                  out_valid, out_valid_next;
  logic [OUT_DATA_W-1:0] out_data, out_data_next;

  logic                  link_we;
  logic [IDX_W-1:0]      link_waddr;
  logic [IDX_W-1:0]      link_wdata;
  logic                  val_we;
  logic [IDX_W-1:0]      rd_addr;
  logic [IDX_W-1:0]      rd_link;
  logic [DATA_WIDTH-1:0] rd_val;

  logic [63:0]           v_ext;
  logic [DATA_WIDTH-1:0] v_in;
  logic                  live;
  logic                  fresh;
  logic [IDX_W-1:0]      virgin_next;
  logic [IDX_W+5:0]      pos_wide;

  assign v_ext = {{32{s_tdata[VALUE_W-1]}}, s_tdata[VALUE_W-1:0]};
  assign v_in  = v_ext[DATA_WIDTH-1:0];

  assign live  = (cur != '0) && ({1'b0, cur} < NODES_C) && (steps < NODES_C);
  // nodes at or above the fill mark were never handed out: link is implicit
  assign fresh       = ({1'b0, cur} >= hwm);
  assign virgin_next = (cur == LAST_NODE) ? '0 : cur + IDX_W'(1);
  assign pos_wide    = {6'b0, res_pos};

  assign s_tready = (state == ST_IDLE) && !rst;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  sllm_ram #(.WIDTH(IDX_W), .DEPTH(NODES)) u_link_ram (
    .clk  (clk),
    .we   (link_we),
    .waddr(link_waddr),
    .wdata(link_wdata),
    .raddr(rd_addr),
    .rdata(rd_link)
  );

  sllm_ram #(.WIDTH(DATA_WIDTH), .DEPTH(NODES)) u_value_ram (
    .clk  (clk),
    .we   (val_we),
    .waddr(cur),
    .wdata(val_q),
    .raddr(rd_addr),
    .rdata(rd_val)
  );

  always_comb begin
    state_next      = state;
    cmd_next        = cmd_q;
    val_next        = val_q;
    cur_next        = cur;
    prev_next       = prev;
    steps_next      = steps;
    dirty_next      = dirty;
    head_next       = head;
    free_head_next  = free_head;
    hwm_next        = hwm;
    res_pos_next    = res_pos;
    res_found_next  = res_found;
    res_status_next = res_status;
    out_valid_next  = out_valid;
    out_data_next   = out_data;
    link_we         = 1'b0;
    link_waddr      = cur;
    link_wdata      = head;
    val_we          = 1'b0;
    rd_addr         = cur;

    if (m_tready) begin
      out_valid_next = 1'b0;
    end

    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd_next        = cmd_t'(s_tuser[CMD_W-1:0]);
          val_next        = v_in;
          prev_next       = '0;
          steps_next      = '0;
          dirty_next      = 1'b0;
          res_pos_next    = '0;
          res_found_next  = 1'b0;
          res_status_next = 1'b0;
          case (cmd_t'(s_tuser[CMD_W-1:0]))
            CMD_INSERT: begin
              cur_next   = free_head;
              rd_addr    = free_head;
              state_next = ST_STEP;
            end
            CMD_FIND, CMD_DELETE, CMD_REVERSE: begin
              cur_next   = head;
              rd_addr    = head;
              state_next = ST_STEP;
            end
            CMD_CLEAR: begin
              head_next      = '0;
              free_head_next = FIRST_NODE;
              hwm_next       = CNT_W'(2);
              state_next     = ST_RESULT;
            end
            default: begin
              state_next = ST_RESULT;
            end
          endcase
        end
      end

      ST_STEP: begin
        case (cmd_q)
          CMD_INSERT: begin
            state_next = ST_RESULT;
            if (live) begin
              free_head_next = fresh ? virgin_next : rd_link;
              if (fresh) begin
                hwm_next = {1'b0, cur} + CNT_W'(1);
              end
              link_we      = 1'b1;
              link_waddr   = cur;
              link_wdata   = head;
              val_we       = 1'b1;
              head_next    = cur;
              res_pos_next = cur;
            end else begin
              res_status_next = 1'b1;
            end
          end

          CMD_FIND: begin
            if (!live) begin
              state_next = ST_RESULT;
            end else if (rd_val == val_q) begin
              res_pos_next   = cur;
              res_found_next = 1'b1;
              state_next     = ST_RESULT;
            end else begin
              cur_next   = rd_link;
              steps_next = steps + CNT_W'(1);
              rd_addr    = rd_link;
            end
          end

          CMD_DELETE: begin
            if (!live || (rd_val != val_q)) begin
              // close a run of removed nodes: predecessor skips to this node
              if (dirty) begin
                if (prev == '0) begin
                  head_next = cur;
                end else begin
                  link_we    = 1'b1;
                  link_waddr = prev;
                  link_wdata = cur;
                end
              end
            end
            if (!live) begin
              state_next = ST_RESULT;
            end else begin
              if (rd_val == val_q) begin
                link_we        = 1'b1;
                link_waddr     = cur;
                link_wdata     = free_head;
                free_head_next = cur;
                dirty_next     = 1'b1;
                res_found_next = 1'b1;
              end else begin
                prev_next  = cur;
                dirty_next = 1'b0;
              end
              cur_next   = rd_link;
              steps_next = steps + CNT_W'(1);
              rd_addr    = rd_link;
            end
          end

          CMD_REVERSE: begin
            if (!live) begin
              head_next  = prev;
              state_next = ST_RESULT;
            end else begin
              link_we    = 1'b1;
              link_waddr = cur;
              link_wdata = prev;
              prev_next  = cur;
              cur_next   = rd_link;
              steps_next = steps + CNT_W'(1);
              rd_addr    = rd_link;
            end
          end

          default: begin
            state_next = ST_RESULT;
          end
        endcase
      end

      ST_RESULT: begin
        // hold the result until the output register is free
        if (!out_valid || m_tready) begin
          out_valid_next = 1'b1;
          out_data_next  = {6'b0, (free_head == '0), (head == '0), res_status,
                            res_found, pos_wide[POS_W-1:0]};
          state_next     = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      free_head <= FIRST_NODE;
      hwm       <= CNT_W'(2);
      out_valid <= 1'b0;
      steps     <= '0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      free_head <= free_head_next;
      hwm       <= hwm_next;
      out_valid <= out_valid_next;
      steps     <= steps_next;
    end
    cmd_q      <= cmd_next;
    val_q      <= val_next;
    cur        <= cur_next;
    prev       <= prev_next;
    dirty      <= dirty_next;
    res_pos    <= res_pos_next;
    res_found  <= res_found_next;
    res_status <= res_status_next;
    out_data   <= out_data_next;
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second command taken while one is running");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    steps <= NODES_C)
    else $error("walk ran past the node count");

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    (hwm >= CNT_W'(2)) && (hwm <= NODES_C))
    else $error("fill mark out of range");

  a_full_fill: assert property (@(posedge clk) disable iff (rst)
    (free_head == '0) |-> (hwm == NODES_C))
    else $error("free chain empty while fresh nodes remain");

endmodule

/* verif/tb_top.sv */
// Testbench for static_linked_list_manager: directed, fill-to-full and random command
// streams, checked against a behavioral list model with its own copy of the link store.
// Depends on sllm_pkg and the RTL of the block only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sllm_pkg::*;

  localparam int NODES        = NODES_DEFAULT;
  localparam int LIST_HEAD    = 0;
  localparam int FREE_HEAD    = 1;
  localparam int FIRST_NODE   = 2;
  localparam int NIL          = 0;
  localparam int CMD_CODE_MAX = (1 << CMD_W) - 1;
  localparam int POOL_SIZE    = 6;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 3 * NODES;

  localparam logic [VALUE_W-1:0] VAL_MIN      = 32'h8000_0000;
  localparam logic [VALUE_W-1:0] VAL_MAX      = 32'h7FFF_FFFF;
  localparam logic [VALUE_W-1:0] VAL_ALL_ONES = 32'hFFFF_FFFF;
  localparam logic [VALUE_W-1:0] VAL_ZERO     = 32'h0000_0000;
  localparam logic [VALUE_W-1:0] VAL_ABSENT   = 32'h1234_5678;

  // bits from the top: full_res, empty_res, status, found, position
  typedef struct packed {
    logic             full_res;
    logic             empty_res;
    logic             status;
    logic             found;
    logic [POS_W-1:0] position;
  } list_result_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic [IN_USER_W-1:0]  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;

  int                 link_mem[NODES];
  logic [VALUE_W-1:0] value_mem[NODES];
  list_result_t       expected_results[$];
  logic [VALUE_W-1:0] value_pool[POOL_SIZE];
  int                 error_count = 0;
  int                 idle_cycles = 0;
  bit                 no_gaps = 1'b0;

  static_linked_list_manager #(
    .NODES(NODES),
    .DATA_WIDTH(DATA_WIDTH_DEFAULT)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // ---------------------------------------------------------------- list model

  function automatic void rebuild_chains();
    for (int i = FREE_HEAD; i + 1 < NODES; i++) link_mem[i] = i + 1;
    link_mem[NODES-1] = NIL;
    link_mem[LIST_HEAD] = NIL;
  endfunction

  function automatic bit walkable(int idx, int steps);
    return idx != NIL && idx < NODES && steps < NODES;
  endfunction

  function automatic list_result_t predict_list_cmd(logic [CMD_W-1:0] code,
                                                    logic [VALUE_W-1:0] val);
    list_result_t res;
    int cur, prev, nxt, steps;
    res = '0;
    steps = 0;
    prev = LIST_HEAD;
    case (code)
      CMD_INSERT: begin
        cur = link_mem[FREE_HEAD];
        if (cur != NIL && cur < NODES) begin
          link_mem[FREE_HEAD] = link_mem[cur];
          value_mem[cur] = val;
          link_mem[cur] = link_mem[LIST_HEAD];
          link_mem[LIST_HEAD] = cur;
          res.position = cur[POS_W-1:0];
        end else begin
          res.status = 1'b1;
        end
      end
      CMD_FIND: begin
        cur = link_mem[LIST_HEAD];
        while (walkable(cur, steps)) begin
          if (value_mem[cur] == val) begin
            res.position = cur[POS_W-1:0];
            res.found = 1'b1;
            break;
          end
          cur = link_mem[cur];
          steps++;
        end
      end
      CMD_DELETE: begin
        cur = link_mem[LIST_HEAD];
        while (walkable(cur, steps)) begin
          nxt = link_mem[cur];
          if (value_mem[cur] == val) begin
            // unlink and push onto the free chain head
            link_mem[prev] = nxt;
            link_mem[cur] = link_mem[FREE_HEAD];
            link_mem[FREE_HEAD] = cur;
            res.found = 1'b1;
          end else begin
            prev = cur;
          end
          cur = nxt;
          steps++;
        end
      end
      CMD_REVERSE: begin
        cur = link_mem[LIST_HEAD];
        while (walkable(cur, steps)) begin
          nxt = link_mem[cur];
          link_mem[cur] = prev;
          prev = cur;
          cur = nxt;
          steps++;
        end
        link_mem[LIST_HEAD] = prev;
      end
      CMD_CLEAR: rebuild_chains();
      default: ;
    endcase
    res.empty_res = (link_mem[LIST_HEAD] == NIL);
    res.full_res  = (link_mem[FREE_HEAD] == NIL);
    return res;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [VALUE_W-1:0] pick_extreme();
    case ($urandom_range(0, 4))
      0: return VAL_ZERO;
      1: return VAL_ALL_ONES;
      2: return VAL_MIN;
      3: return VAL_MAX;
      default: return $urandom_range(0, 15);
    endcase
  endfunction

  function automatic void refresh_pool();
    value_pool[0] = $urandom;
    value_pool[1] = $urandom;
    for (int i = 2; i < POOL_SIZE; i++) value_pool[i] = pick_extreme();
  endfunction

  // mostly pool values so that finds and deletes hit, some fully random
  function automatic logic [VALUE_W-1:0] pick_value();
    if ($urandom_range(0, 99) < 85) return value_pool[$urandom_range(0, POOL_SIZE-1)];
    return $urandom;
  endfunction

  task automatic send_cmd(input logic [CMD_W-1:0] code, input logic [VALUE_W-1:0] val);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= {{(IN_USER_W-CMD_W){1'b0}}, code};
    s_tdata  <= val;
    do @(posedge clk); while (!s_tready);
    expected_results.push_back(predict_list_cmd(code, val));
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("tb: %s mismatch at %0t ns: got %0h, expected %0h", field, $realtime, got,
             want);
    error_count++;
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_directed();
    send_cmd(CMD_REVERSE, VAL_ZERO);
    send_cmd(CMD_FIND, VAL_ZERO);
    send_cmd(CMD_DELETE, VAL_ZERO);
    send_cmd(CMD_INSERT, VAL_MIN);
    send_cmd(CMD_REVERSE, VAL_ZERO);
    send_cmd(CMD_FIND, VAL_MIN);
    send_cmd(CMD_INSERT, VAL_MAX);
    send_cmd(CMD_INSERT, VAL_ZERO);
    send_cmd(CMD_INSERT, VAL_ALL_ONES);
    send_cmd(CMD_INSERT, VAL_ALL_ONES);
    send_cmd(CMD_FIND, VAL_ALL_ONES);
    send_cmd(CMD_FIND, VAL_ABSENT);
    send_cmd(CMD_REVERSE, VAL_ABSENT);
    send_cmd(CMD_FIND, VAL_MIN);
    send_cmd(CMD_DELETE, VAL_ALL_ONES);
    send_cmd(CMD_DELETE, VAL_ALL_ONES);
    send_cmd(CMD_INSERT, VAL_ZERO);
    for (int c = CMD_CLEAR + 1; c <= CMD_CODE_MAX; c++) send_cmd(CMD_W'(c), VAL_ALL_ONES);
    send_cmd(CMD_DELETE, VAL_ZERO);
    send_cmd(CMD_CLEAR, VAL_MAX);
    send_cmd(CMD_FIND, VAL_MAX);
    send_cmd(CMD_INSERT, VAL_MAX);
  endtask

  task automatic test_fill_to_full();
    refresh_pool();
    send_cmd(CMD_CLEAR, VAL_ZERO);
    repeat (NODES - FIRST_NODE) send_cmd(CMD_INSERT, pick_value());
    // refused while full
    repeat (3) send_cmd(CMD_INSERT, pick_value());
    send_cmd(CMD_FIND, value_pool[0]);
    send_cmd(CMD_FIND, value_pool[POOL_SIZE-1]);
    send_cmd(CMD_REVERSE, VAL_ZERO);
    send_cmd(CMD_FIND, value_pool[1]);
    send_cmd(CMD_DELETE, value_pool[2]);
    send_cmd(CMD_INSERT, VAL_MIN);
    send_cmd(CMD_INSERT, VAL_MAX);
    send_cmd(CMD_CLEAR, VAL_ZERO);
  endtask

  task automatic test_random_mix(input int item_total);
    int sent, seg_len, insert_pct, r;
    logic [CMD_W-1:0] code;
    sent = 0;
    while (sent < item_total) begin
      seg_len = $urandom_range(20, 80);
      case ($urandom_range(0, 3))
        0: insert_pct = 20;
        1: insert_pct = 45;
        2: insert_pct = 65;
        default: insert_pct = 90;
      endcase
      no_gaps = ($urandom_range(0, 4) == 0);
      refresh_pool();
      repeat (seg_len) begin
        if ($urandom_range(0, 99) < insert_pct) begin
          code = CMD_INSERT;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 40) code = CMD_FIND;
          else if (r < 70) code = CMD_DELETE;
          else if (r < 88) code = CMD_REVERSE;
          else if (r < 95) code = CMD_CLEAR;
          else code = CMD_W'($urandom_range(CMD_CLEAR + 1, CMD_CODE_MAX));
        end
        send_cmd(code, pick_value());
        sent++;
      end
    end
    no_gaps = 1'b0;
  endtask

  // ---------------------------------------------------------------- result checker

  initial begin : result_check
    list_result_t got, want;
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        got = list_result_t'(m_tdata[$bits(list_result_t)-1:0]);
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected transfer", 32'(m_tdata), 32'd0);
        end else begin
          want = expected_results.pop_front();
          if (got.position !== want.position)
            report_mismatch("position", 32'(got.position), 32'(want.position));
          if (got.found !== want.found)
            report_mismatch("found", 32'(got.found), 32'(want.found));
          if (got.status !== want.status)
            report_mismatch("status", 32'(got.status), 32'(want.status));
          if (got.empty_res !== want.empty_res)
            report_mismatch("empty_res", 32'(got.empty_res), 32'(want.empty_res));
          if (got.full_res !== want.full_res)
            report_mismatch("full_res", 32'(got.full_res), 32'(want.full_res));
        end
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        stall--;
      end else begin
        m_tready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  // end the run when neither side has moved a transfer for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    m_tready = 1'b0;
    for (int i = 0; i < NODES; i++) value_mem[i] = '0;
    rebuild_chains();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_fill_to_full();
    test_random_mix(800);

    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
